>>> rtl/bmp_pkg.sv
package bmp_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_VALUE = 3'd1,
      PH_DX    = 3'd2,
      PH_DY    = 3'd3,
      PH_ABS   = 3'd4,
      PH_PAD   = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_RUN = 2'd0,
      KIND_OK  = 2'd1,
      KIND_ERR = 2'd2
   } kind_type;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_TOP_DOWN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FOUR_BIT_MODE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STREAM_LENGTH = 3'd4;

   // escape codes in the second byte of a zero-count pair
   localparam logic [7:0] ESC_END_OF_LINE   = 8'h00;
   localparam logic [7:0] ESC_END_OF_BITMAP = 8'h01;
   localparam logic [7:0] ESC_DELTA         = 8'h02;

   // column and row saturate here
   localparam logic [16:0] COORD_MAX = 17'h1FFFF;

   // depth of the result queue, at least two
   localparam int RSP_QUEUE_DEPTH = 4;

   // one result item
   typedef struct packed {
      kind_type    kind;
      logic [15:0] memory_row;
      logic [15:0] start_column;
      logic [7:0]  run_length;
      logic [7:0]  pixel_value;
      logic        last_of_item;
   } rsp_item_type;

   // results of one byte pushed into the queue, first then second
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

endpackage

>>> rtl/bmp_req_if.sv
interface bmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

>>> rtl/bmp_rsp_if.sv
interface bmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] memory_row;
   logic [15:0] start_column;
   logic [7:0]  run_length;
   logic [7:0]  pixel_value;
   logic        last_of_item;

   modport source (
      output valid, output result_kind, output memory_row, output start_column,
      output run_length, output pixel_value, output last_of_item, input ready
   );
   modport sink (
      input valid, input result_kind, input memory_row, input start_column,
      input run_length, input pixel_value, input last_of_item, output ready
   );
endinterface

>>> rtl/bmp_rsp_queue.sv
module bmp_rsp_queue import bmp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         has_room,
   bmp_rsp_if.source    rsp_if
);

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);

   rsp_item_type     entry_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic             pop;

   // room for the two results a byte may cause
   assign has_room = count_ff <= (PTR_W+1)'(RSP_QUEUE_DEPTH - 2);

   // head item drives the result channel
   assign pop                 = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid        = count_ff != '0;
   assign rsp_if.result_kind  = entry_ff[rd_ptr_ff].kind;
   assign rsp_if.memory_row   = entry_ff[rd_ptr_ff].memory_row;
   assign rsp_if.start_column = entry_ff[rd_ptr_ff].start_column;
   assign rsp_if.run_length   = entry_ff[rd_ptr_ff].run_length;
   assign rsp_if.pixel_value  = entry_ff[rd_ptr_ff].pixel_value;
   assign rsp_if.last_of_item = entry_ff[rd_ptr_ff].last_of_item;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[PTR_W'(wr_ptr_ff + PTR_W'(1))] <= push.second;
      end
   end

endmodule

>>> rtl/bmp_rle_decoder.sv
// BMP RLE8/RLE4 stream decoder, one compressed byte per item.
// Results are registered in the result queue before they reach rsp_if.
// Throughput: one byte per cycle while the queue has room for two results;
// a run and a status from one byte are buffered in a four-entry result queue.
// Reset: synchronous; parser state and queue cleared, registers take
// width 1, height 1, bottom-up, RLE8, stream length 0.
module bmp_rle_decoder import bmp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bmp_req_if.sink                req_if,
   bmp_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic        rows_top_first_ff;
   logic        four_bit_mode_ff;
   logic [23:0] stream_length_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  pending_ff, pending_in;
   logic [23:0] position_ff, position_in;
   logic [16:0] column_ff, column_in;
   logic [16:0] row_ff, row_in;
   logic [7:0]  abs_left_ff, abs_left_in;
   logic        pad_ff, pad_in;
   logic [7:0]  dx_hold_ff, dx_hold_in;

   // state as seen by this byte, after a frame restart
   phase_type   cur_phase;
   logic [7:0]  cur_pending;
   logic [23:0] cur_position;
   logic [16:0] cur_column;
   logic [16:0] cur_row;
   logic [7:0]  cur_abs_left;
   logic        cur_pad;
   logic [7:0]  cur_dx_hold;

   logic         accept;
   logic         room;
   logic [7:0]   data;
   logic [23:0]  pos_next;
   logic [8:0]   abs_bytes;
   logic [7:0]   abs_pixels;
   logic [16:0]  row_plus_one;
   logic         draw_en;
   logic [7:0]   draw_pixels;
   logic         draw_hit;
   logic [15:0]  avail;
   logic [7:0]   clip_len;
   logic [15:0]  mem_row;
   logic         run_emit;
   logic         fin_en;
   kind_type     fin_kind;
   rsp_item_type run_item;
   rsp_item_type fin_item;
   rsp_push_type push;

   function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
      logic [17:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[17] ? COORD_MAX : s[16:0];
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= 16'd1;
         image_height_ff   <= 16'd1;
         rows_top_first_ff <= 1'b0;
         four_bit_mode_ff  <= 1'b0;
         stream_length_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   image_width_ff    <= csr_wdata[15:0];
            REG_IMAGE_HEIGHT:  image_height_ff   <= csr_wdata[15:0];
            REG_ROWS_TOP_DOWN: rows_top_first_ff <= csr_wdata[0];
            REG_FOUR_BIT_MODE: four_bit_mode_ff  <= csr_wdata[0];
            REG_STREAM_LENGTH: stream_length_ff  <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = room;
   assign data         = req_if.data_byte;

   // frame start restarts the parser before the byte is taken
   always_comb begin
      if (req_if.frame_start) begin
         cur_phase    = PH_COUNT;
         cur_pending  = '0;
         cur_position = '0;
         cur_column   = '0;
         cur_row      = '0;
         cur_abs_left = '0;
         cur_pad      = 1'b0;
         cur_dx_hold  = '0;
      end else begin
         cur_phase    = phase_ff;
         cur_pending  = pending_ff;
         cur_position = position_ff;
         cur_column   = column_ff;
         cur_row      = row_ff;
         cur_abs_left = abs_left_ff;
         cur_pad      = pad_ff;
         cur_dx_hold  = dx_hold_ff;
      end
   end

   // byte-level helpers
   always_comb begin
      pos_next     = cur_position + 24'd1;
      abs_bytes    = four_bit_mode_ff ? 9'(({1'b0, data} + 9'd1) >> 1) : {1'b0, data};
      row_plus_one = sat_add(cur_row, 17'd1);
      if (four_bit_mode_ff && cur_abs_left >= 8'd2) begin
         abs_pixels = 8'd2;
      end else if (cur_abs_left == 8'd0) begin
         abs_pixels = 8'd0;
      end else begin
         abs_pixels = 8'd1;
      end
   end

   // draw: clip to the width and map the row to memory order
   always_comb begin
      draw_en     = (cur_phase == PH_VALUE && cur_pending != 8'd0) || cur_phase == PH_ABS;
      draw_pixels = (cur_phase == PH_ABS) ? abs_pixels : cur_pending;
      draw_hit    = cur_row < {1'b0, image_height_ff} && cur_column < {1'b0, image_width_ff};
      avail       = image_width_ff - cur_column[15:0];
      clip_len    = ({8'd0, draw_pixels} <= avail) ? draw_pixels : avail[7:0];
      mem_row     = rows_top_first_ff ? cur_row[15:0]
                                      : image_height_ff - 16'd1 - cur_row[15:0];
   end

   // parser next state
   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      position_in = position_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      abs_left_in = abs_left_ff;
      pad_in      = pad_ff;
      dx_hold_in  = dx_hold_ff;
      run_emit    = 1'b0;
      fin_en      = 1'b0;
      fin_kind    = KIND_ERR;

      if (accept && cur_phase != PH_DONE) begin
         phase_in    = cur_phase;
         pending_in  = cur_pending;
         position_in = cur_position;
         column_in   = cur_column;
         row_in      = cur_row;
         abs_left_in = cur_abs_left;
         pad_in      = cur_pad;
         dx_hold_in  = cur_dx_hold;

         if (cur_position >= stream_length_ff) begin
            // stream already used up
            fin_en   = 1'b1;
            phase_in = PH_DONE;
         end else begin
            position_in = pos_next;
            if (draw_en) begin
               run_emit  = draw_hit && clip_len != 8'd0;
               column_in = sat_add(cur_column, {9'd0, draw_pixels});
            end
            case (cur_phase)
               PH_COUNT: begin
                  pending_in = data;
                  phase_in   = PH_VALUE;
               end
               PH_VALUE: begin
                  phase_in = PH_COUNT;
                  if (cur_pending != 8'd0) begin
                     phase_in = PH_COUNT;
                  end else if (data == ESC_END_OF_LINE) begin
                     column_in = '0;
                     row_in    = row_plus_one;
                     if (row_plus_one > {1'b0, image_height_ff}) begin
                        fin_en   = 1'b1;
                        phase_in = PH_DONE;
                     end
                  end else if (data == ESC_END_OF_BITMAP) begin
                     fin_en   = 1'b1;
                     fin_kind = KIND_OK;
                     phase_in = PH_DONE;
                  end else if (data == ESC_DELTA) begin
                     if ({1'b0, pos_next} + 25'd2 > {1'b0, stream_length_ff}) begin
                        fin_en   = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_DX;
                     end
                  end else begin
                     if ({1'b0, pos_next} + 25'(abs_bytes) > {1'b0, stream_length_ff}) begin
                        fin_en   = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        abs_left_in = data;
                        pad_in      = abs_bytes[0];
                        phase_in    = PH_ABS;
                     end
                  end
               end
               PH_DX: begin
                  dx_hold_in = data;
                  phase_in   = PH_DY;
               end
               PH_DY: begin
                  column_in = sat_add(cur_column, {9'd0, cur_dx_hold});
                  row_in    = sat_add(cur_row, {9'd0, data});
                  phase_in  = PH_COUNT;
               end
               PH_ABS: begin
                  abs_left_in = cur_abs_left - abs_pixels;
                  if (cur_abs_left == abs_pixels) begin
                     phase_in = cur_pad ? PH_PAD : PH_COUNT;
                  end
               end
               PH_PAD: begin
                  phase_in = PH_COUNT;
               end
               default: begin
                  phase_in = PH_COUNT;
               end
            endcase
            // last byte of the stream without end of bitmap
            if (!fin_en && pos_next >= stream_length_ff) begin
               fin_en   = 1'b1;
               fin_kind = KIND_ERR;
               phase_in = PH_DONE;
            end
         end
      end
   end

   // results of this byte
   always_comb begin
      run_item.kind         = KIND_RUN;
      run_item.memory_row   = mem_row;
      run_item.start_column = cur_column[15:0];
      run_item.run_length   = clip_len;
      run_item.pixel_value  = data;
      run_item.last_of_item = !fin_en;

      fin_item.kind         = fin_kind;
      fin_item.memory_row   = '0;
      fin_item.start_column = '0;
      fin_item.run_length   = '0;
      fin_item.pixel_value  = '0;
      fin_item.last_of_item = 1'b1;

      push.count  = 2'(run_emit) + 2'(fin_en);
      push.first  = run_emit ? run_item : fin_item;
      push.second = fin_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         pending_ff  <= '0;
         position_ff <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
         abs_left_ff <= '0;
         pad_ff      <= 1'b0;
         dx_hold_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         pending_ff  <= pending_in;
         position_ff <= position_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         abs_left_ff <= abs_left_in;
         pad_ff      <= pad_in;
         dx_hold_ff  <= dx_hold_in;
      end
   end

   // result queue and output channel
   bmp_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .has_room (room),
      .rsp_if   (rsp_if)
   );

endmodule
